// File: sv/fixed_block_free_list_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; include with the bare file name.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define FBFL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("allocator assertion failed");
// Condition must never be true outside reset.
`define FBFL_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("allocator forbidden condition seen");
`else
`define FBFL_ASSERT(lbl, clk, rst, prop)
`define FBFL_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: sv/fbfl_pkg.sv
// Shared types and constants of the fixed block free list allocator.
// No dependencies.
package fbfl_pkg;

   localparam int OP_W          = 2;
   localparam int FREE_INDEX_W  = 8;
   localparam int GIVEN_INDEX_W = 8;
   localparam int OFFSET_W      = 24;
   localparam int COUNT_W       = 9;
   localparam int BYTES_W       = 16;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic REG_BLOCKS_IN_USE = 1'b0;
   localparam logic REG_BLOCK_BYTES   = 1'b1;

   localparam logic [COUNT_W-1:0] BLOCKS_IN_USE_RESET = 9'd256;
   localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET   = 16'd8;
   localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES     = 16'd8;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0] blocks_in_use;
      logic [BYTES_W-1:0] block_bytes;
   } cfg_type;

endpackage

// File: sv/fbfl_req_if.sv
// Request channel: operation and index of a block being returned.
// Depends on fbfl_pkg.
interface fbfl_req_if;
   import fbfl_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [FREE_INDEX_W-1:0] free_index;

   modport source (output valid, output operation, output free_index, input ready);
   modport sink   (input valid, input operation, input free_index, output ready);
endinterface

// File: sv/fbfl_rsp_if.sv
// Response channel: status, index and byte offset of an allocated block.
// Depends on fbfl_pkg.
interface fbfl_rsp_if;
   import fbfl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     status;
   logic [GIVEN_INDEX_W-1:0] given_index;
   logic [OFFSET_W-1:0]      given_offset;

   modport source (output valid, output status, output given_index, output given_offset,
                   input ready);
   modport sink   (input valid, input status, input given_index, input given_offset,
                   output ready);
endinterface

// File: sv/fbfl_csr.sv
// APB-style configuration registers: block count and block size.
// Depends on fbfl_pkg.
module fbfl_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fbfl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fbfl_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fbfl_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output fbfl_pkg::cfg_type                 cfg
);
   import fbfl_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Word-aligned decode: address bit 2 picks the register.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_BLOCKS_IN_USE: cfg_in.blocks_in_use = pwdata[COUNT_W-1:0];
            REG_BLOCK_BYTES:   cfg_in.block_bytes   = pwdata[BYTES_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blocks_in_use <= BLOCKS_IN_USE_RESET;
         cfg_ff.block_bytes   <= BLOCK_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_BLOCKS_IN_USE: prdata = CSR_DATA_W'(cfg_ff.blocks_in_use);
         REG_BLOCK_BYTES:   prdata = CSR_DATA_W'(cfg_ff.block_bytes);
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

// File: sv/fixed_block_free_list_allocator.sv
// Fixed-size block pool allocator. The free blocks form a singly linked list held in a
// one-port-read, one-port-write link memory of MAX_BLOCKS entries, with the list head in
// a register. An allocate transaction pops the head and returns its index and byte
// offset (index times max(block_bytes, 8), low 24 bits); on an empty list it returns
// status 1. A free transaction pushes the given index (indexes not below MAX_BLOCKS are
// ignored). A clear transaction relinks blocks 0 .. blocks_in_use-1 in order. One request
// is handled at a time. Allocate, free and the unused code pass through the EXEC state to
// the response register: the link memory read is registered at acceptance, and the head
// update and offset multiply follow in EXEC. A clear sweeps the link memory one entry per
// cycle and then passes through EXEC to respond. After reset the same sweep runs with 256
// blocks (or MAX_BLOCKS if smaller); no request is accepted during it, while configuration
// writes are taken as usual. The response register lets a finished response wait while
// the next request is accepted; a response is only dropped into it once the previous one
// has been taken.
// Depends on fbfl_pkg, fbfl_req_if, fbfl_rsp_if, fbfl_csr and the assertion macros.
`include "fixed_block_free_list_allocator_macros.svh"
module fixed_block_free_list_allocator #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   fbfl_req_if.sink                          req,
   fbfl_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fbfl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fbfl_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fbfl_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import fbfl_pkg::*;

   // Index width and link width; a link holds an index or the null value MAX_BLOCKS.
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);
   localparam logic [LW-1:0] RESET_COUNT =
      (int'(BLOCKS_IN_USE_RESET) > MAX_BLOCKS) ? LW'(MAX_BLOCKS) : LW'(BLOCKS_IN_USE_RESET);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   cfg_type cfg;

   fbfl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   state_type               state_ff, state_in;
   logic [LW-1:0]           head_ff, head_in;
   logic [LW-1:0]           count_ff, count_in;
   logic [IW-1:0]           sweep_ff, sweep_in;
   logic                    reply_ff, reply_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    status_ff, status_in;
   logic [GIVEN_INDEX_W-1:0] index_ff, index_in;
   logic [OFFSET_W-1:0]     offset_ff, offset_in;

   // Link memory and its registered read port.
   logic [LW-1:0]           link_mem [MAX_BLOCKS];
   logic [LW-1:0]           link_rd_ff;
   logic                    mem_we, mem_re;
   logic [IW-1:0]           mem_waddr;
   logic [LW-1:0]           mem_wdata;

   logic                    accept, head_null, idx_ok, sweep_last, out_free;
   logic [LW-1:0]           head_norm, next_norm, sweep_next, clamp_count;
   logic [BYTES_W-1:0]      eff_bytes;
   logic [31:0]             product;

   assign accept     = req.valid && req.ready;
   assign req.ready  = (state_ff == ST_IDLE);
   assign head_null  = (head_ff >= LINK_NULL);
   assign head_norm  = head_null ? LINK_NULL : head_ff;
   assign idx_ok     = (32'(req.free_index) < 32'(MAX_BLOCKS));
   assign next_norm  = (link_rd_ff >= LINK_NULL) ? LINK_NULL : link_rd_ff;
   assign sweep_last = (sweep_ff == IW'(MAX_BLOCKS - 1));
   assign sweep_next = LW'(sweep_ff) + LW'(1);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign eff_bytes  = (cfg.block_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : cfg.block_bytes;
   assign product    = 32'(head_ff[IW-1:0]) * 32'(eff_bytes);
   // Counts above the pool size link the whole pool.
   assign clamp_count = (32'(cfg.blocks_in_use) > 32'(MAX_BLOCKS)) ?
                        LW'(MAX_BLOCKS) : LW'(cfg.blocks_in_use);

   // Memory port control: the sweep owns the write port, a free writes at acceptance,
   // an allocate reads the head entry at acceptance.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = (sweep_next < count_ff) ? sweep_next : LINK_NULL;
      mem_re    = 1'b0;
      if (state_ff == ST_SWEEP) begin
         mem_we = !reset;
      end else if (accept && (req.operation == OP_FREE) && idx_ok) begin
         mem_we    = 1'b1;
         mem_waddr = IW'(req.free_index);
         mem_wdata = head_norm;
      end
      if (accept && (req.operation == OP_ALLOC) && !head_null) begin
         mem_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         link_rd_ff <= link_mem[head_ff[IW-1:0]];
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      sweep_in     = sweep_ff;
      reply_in     = reply_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      index_in     = index_ff;
      offset_in    = offset_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req.operation;
               case (req.operation)
                  OP_FREE: begin
                     if (idx_ok) begin
                        head_in = LW'(req.free_index);
                     end
                     state_in = ST_EXEC;
                  end
                  OP_CLEAR: begin
                     // Latch the count now; the sweep relinks from entry 0.
                     count_in = clamp_count;
                     sweep_in = '0;
                     reply_in = 1'b1;
                     state_in = ST_SWEEP;
                  end
                  default: state_in = ST_EXEC;
               endcase
            end
         end
         ST_EXEC: begin
            // Hold until the response register is free, then drop the response in.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_DONE;
               index_in     = '0;
               offset_in    = '0;
               if (op_ff == OP_ALLOC) begin
                  if (head_null) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     index_in  = GIVEN_INDEX_W'(head_ff);
                     offset_in = product[OFFSET_W-1:0];
                     head_in   = next_norm;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + IW'(1);
            if (sweep_last) begin
               head_in  = (count_ff == '0) ? LINK_NULL : '0;
               state_in = reply_ff ? ST_EXEC : ST_IDLE;
               reply_in = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         head_ff      <= LINK_NULL;
         count_ff     <= RESET_COUNT;
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      offset_ff <= offset_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.given_index  = index_ff;
   assign rsp.given_offset = offset_ff;

   // A free of an in-range index makes that index the new head.
   `FBFL_ASSERT(a_free_sets_head, clock, reset, accept && (req.operation == OP_FREE) && idx_ok |=> head_ff == LW'($past(req.free_index)))
   // The end of a sweep points the head at block 0, or null for an empty pool.
   `FBFL_ASSERT(a_sweep_sets_head, clock, reset, (state_ff == ST_SWEEP) && sweep_last |=> head_ff == (($past(count_ff) == '0) ? LINK_NULL : '0))
   // The head never holds a value past null.
   `FBFL_ASSERT_NEVER(a_head_range, clock, reset, head_ff > LINK_NULL)
endmodule

// File: tb/fixed_block_free_list_allocator_tb.sv
// Testbench of the fixed block free list allocator: directed and random request streams,
// with a free list tracker class that predicts every response.
// Depends on fbfl_pkg, fbfl_req_if, fbfl_rsp_if and fixed_block_free_list_allocator.
`timescale 1ns / 100ps
module fixed_block_free_list_allocator_tb;
   import fbfl_pkg::*;

   localparam int MAX_BLOCKS = 256;
   localparam logic [COUNT_W-1:0] LINK_NULL = COUNT_W'(MAX_BLOCKS);
   // Byte addresses of the two registers: register i lies at 4*i.
   localparam logic [CSR_ADDR_W-1:0] ADDR_BLOCKS_IN_USE = {REG_BLOCKS_IN_USE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_BLOCK_BYTES   = {REG_BLOCK_BYTES, 2'b00};
   // Cycles with no transaction on any channel before the run is declared hung.
   // The longest quiet stretch in a correct run is the post-reset or clear sweep.
   localparam int STALL_LIMIT = 5000;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 75;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic                     status;
      logic [GIVEN_INDEX_W-1:0] index;
      logic [OFFSET_W-1:0]      offset;
   } grant_type;

   // Tracks the pool's free list and the register copies, and holds the responses
   // still owed by the block, oldest first.
   class free_list_tracker_type;
      logic [COUNT_W-1:0] pool_count;
      logic [BYTES_W-1:0] block_size;
      logic [COUNT_W-1:0] head;
      logic [COUNT_W-1:0] next_free [MAX_BLOCKS];
      grant_type          expected_grants [$];
      int                 errors;

      function new();
         pool_count = BLOCKS_IN_USE_RESET;
         block_size = BLOCK_BYTES_RESET;
         errors = 0;
         relink();
      endfunction

      // Chain blocks 0 .. count-1 in order; a count above the pool size saturates.
      function void relink();
         int count;
         count = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_count);
         for (int i = 0; i < MAX_BLOCKS; i++)
            next_free[i] = (i + 1 < count) ? COUNT_W'(i + 1) : LINK_NULL;
         head = (count == 0) ? LINK_NULL : '0;
      endfunction

      function void write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         if (addr[CSR_ADDR_W-1:2] == REG_BLOCKS_IN_USE)
            pool_count = data[COUNT_W-1:0];
         else
            block_size = data[BYTES_W-1:0];
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [FREE_INDEX_W-1:0] idx);
         grant_type          g;
         logic [COUNT_W-1:0] nxt;
         int                 eff;
         g = '0;
         g.status = STATUS_DONE;
         case (op)
            OP_ALLOC: begin
               if (head >= MAX_BLOCKS) begin
                  g.status = STATUS_EMPTY;
               end else begin
                  nxt = next_free[head];
                  if (nxt >= MAX_BLOCKS)
                     nxt = LINK_NULL;
                  eff = (block_size < MIN_BLOCK_BYTES) ? int'(MIN_BLOCK_BYTES) : int'(block_size);
                  g.index = head[GIVEN_INDEX_W-1:0];
                  g.offset = OFFSET_W'(int'(head) * eff);
                  head = nxt;
               end
            end
            OP_FREE: begin
               // No check against blocks in use: double frees are pushed as well.
               if (idx < MAX_BLOCKS) begin
                  next_free[idx] = (head >= MAX_BLOCKS) ? LINK_NULL : head;
                  head = COUNT_W'(idx);
               end
            end
            OP_CLEAR: relink();
            default: ;
         endcase
         expected_grants.push_back(g);
      endfunction

      function void check_grant(logic status, logic [GIVEN_INDEX_W-1:0] index,
                                logic [OFFSET_W-1:0] offset);
         grant_type g;
         if (expected_grants.size() == 0) begin
            $error("response with no request pending: status %0d index %0d offset %0d",
                   status, index, offset);
            errors++;
            return;
         end
         g = expected_grants.pop_front();
         if (status !== g.status) begin
            $error("status: expected %0d, actual %0d", g.status, status);
            errors++;
         end
         if (index !== g.index) begin
            $error("given_index: expected %0d, actual %0d", g.index, index);
            errors++;
         end
         if (offset !== g.offset) begin
            $error("given_offset: expected %0d, actual %0d", g.offset, offset);
            errors++;
         end
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fbfl_req_if req_if ();
   fbfl_rsp_if rsp_if ();

   free_list_tracker_type tracker = new();

   // Set during the stretch in which neither side idles.
   bit no_idle = 1'b0;
   int grants_seen = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   fixed_block_free_list_allocator #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // Offer one request transaction and hold it until the block takes it. Inputs change
   // on the falling edge; acceptance is judged on the rising edge.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [FREE_INDEX_W-1:0] idx);
      @(negedge clock);
      // Idle the sender now and then, so gaps land on every stage of the block.
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 11) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.free_index <= idx;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      tracker.note_request(op, idx);
   endtask

   // Drop valid once the stream is over or before a pause.
   task automatic release_request();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // Setup cycle, then access cycle; the write lands on the edge with pready high.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      tracker.write_register(addr, data);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Hold the sender until every owed response has come back. Each request yields
   // exactly one response, so the block is idle at that point; add a short margin.
   task automatic wait_drained();
      release_request();
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Reconfigure only with the block idle.
   task automatic set_config(input int count, input int bytes);
      wait_drained();
      write_csr(ADDR_BLOCKS_IN_USE, CSR_DATA_W'(count));
      write_csr(ADDR_BLOCK_BYTES, CSR_DATA_W'(bytes));
   endtask

   // Response side: ready is randomized on the falling edge. Once, with the sender
   // still offering, hold ready low for a long stretch so the block backs up and
   // stalls its input.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!hold_done && grants_seen >= 400 && req_if.valid) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (no_idle)
               rsp_if.ready <= 1'b1;
            else
               rsp_if.ready <= ($urandom_range(0, 99) >= 11);
            @(negedge clock);
         end
      end
   end

   // Check every response transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.check_grant(rsp_if.status, rsp_if.given_index, rsp_if.given_offset);
         grants_seen++;
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int                      count;
      int                      bytes;
      int                      alloc_pct;
      int                      r;
      logic [OP_W-1:0]         op;
      logic [FREE_INDEX_W-1:0] idx;

      // Drive known values on the request channel from time zero.
      req_if.valid = 1'b0;
      req_if.operation = OP_ALLOC;
      req_if.free_index = '0;

      // Synchronous reset, released on a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset registers first: pops in order, a foreign push of the top
      // index, the unused code.
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_FREE, 8'hFF);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_FREE, 8'h00);
      send_request(OP_NONE, 8'hAA);
      send_request(OP_ALLOC, 8'h55);
      // Largest block size, up to the largest offset; then a size below the minimum.
      set_config(MAX_BLOCKS, 65535);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_FREE, 8'hFF);
      send_request(OP_ALLOC, 8'h00);
      set_config(MAX_BLOCKS, 0);
      send_request(OP_ALLOC, 8'h00);
      // Zero block count: clear leaves the list empty, allocate reports empty.
      set_config(0, 7);
      send_request(OP_CLEAR, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_FREE, 8'h55);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      // Single block, then a double free that links the block to itself.
      set_config(1, 1);
      send_request(OP_CLEAR, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      send_request(OP_FREE, 8'h00);
      send_request(OP_FREE, 8'h00);
      send_request(OP_ALLOC, 8'h00);
      // Count above the pool size saturates.
      set_config(511, 9);
      send_request(OP_CLEAR, 8'h00);
      send_request(OP_ALLOC, 8'h00);

      // Random part: each phase reconfigures, clears, then runs a mix biased toward
      // allocates and frees of live blocks, so small pools run empty and refill.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin count = MAX_BLOCKS; bytes = 8; end
            1: begin count = 1; bytes = 65535; end
            2: begin count = 0; bytes = 0; end
            3: begin count = 511; bytes = 7; end
            default: begin
               count = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 511)
                                                    : $urandom_range(2, 16);
               bytes = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 64);
            end
         endcase
         set_config(count, bytes);
         if (count > MAX_BLOCKS)
            count = MAX_BLOCKS;
         // No idling on either side for two whole phases.
         no_idle = (phase == 5 || phase == 6);
         alloc_pct = $urandom_range(35, 70);
         send_request(OP_CLEAR, FREE_INDEX_W'($urandom_range(0, 255)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
               op = OP_ALLOC;
            else if (r < 94)
               op = OP_FREE;
            else if (r < 97)
               op = OP_CLEAR;
            else
               op = OP_NONE;
            // Mostly return blocks of the pool; sometimes any index at all.
            if (count > 0 && $urandom_range(0, 9) < 8)
               idx = FREE_INDEX_W'($urandom_range(0, count - 1));
            else
               idx = FREE_INDEX_W'($urandom_range(0, 255));
            send_request(op, idx);
         end
      end
      no_idle = 1'b0;

      // Drain, then let the block settle before the verdict.
      wait_drained();
      repeat (16) @(posedge clock);
      if (tracker.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
